// ----- design/tmrs_pkg.sv -----
`timescale 1ns / 1ps

package tmrs_pkg;

   // Map geometry and store layout.
   localparam int MAX_COLUMNS   = 64;
   localparam int MAX_ROWS      = 64;
   localparam int TILE_ID_BITS  = 16;
   localparam int MAX_HITS      = 63;
   localparam int COL_BITS      = $clog2(MAX_COLUMNS);
   localparam int ROW_BITS      = $clog2(MAX_ROWS);
   localparam int ADDR_BITS     = COL_BITS + ROW_BITS;
   localparam int STORE_DEPTH   = MAX_COLUMNS * MAX_ROWS;
   localparam int HIT_CNT_BITS  = $clog2(MAX_HITS + 1);
   localparam int POS_CELL_BITS = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;

   // Field widths of the channels and the register port.
   localparam int CELL_BITS      = 16;
   localparam int WORLD_BITS     = 32;
   localparam int FRAC_BITS      = 8;
   localparam int OUT_VALUE_BITS = 16;
   localparam int HIT_FIELD_BITS = 6;
   localparam int CFG_DIM_BITS   = 7;
   localparam int CFG_TILE_BITS  = 11;
   localparam int PROD_BITS      = POS_CELL_BITS + CFG_TILE_BITS;
   localparam int REQ_DATA_BITS  = 160;
   localparam int REQ_USER_BITS  = 2;
   localparam int RSP_DATA_BITS  = 96;
   localparam int RSP_USER_BITS  = 3;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 11;

   // Opcodes.
   localparam logic [REQ_USER_BITS-1:0] OP_WRITE = 2'd0;
   localparam logic [REQ_USER_BITS-1:0] OP_READ  = 2'd1;
   localparam logic [REQ_USER_BITS-1:0] OP_SCAN  = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAP_COLUMNS    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAP_ROWS       = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TILE_WIDTH_PX  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TILE_HEIGHT_PX = 2'd3;

   // Request to the shared position unit: offset + (grid_pos * size << FRAC_BITS).
   typedef struct packed {
      logic [POS_CELL_BITS-1:0] grid_pos;
      logic [CFG_TILE_BITS-1:0] size;
      logic [WORLD_BITS-1:0]    offset;
   } pos_req_type;

   // Forces a map dimension into 1..limit, so zero acts as one.
   function automatic logic [CFG_DIM_BITS-1:0] sat_dim(input logic [CFG_DIM_BITS-1:0] v,
                                                      input int limit);
      logic [CFG_DIM_BITS-1:0] res;
      res = v;
      if (v == '0) begin
         res = CFG_DIM_BITS'(1);
      end else if (v > CFG_DIM_BITS'(limit)) begin
         res = CFG_DIM_BITS'(limit);
      end
      return res;
   endfunction

   // Clamps a signed coordinate into 0..n-1.
   function automatic logic [CFG_DIM_BITS-1:0] clamp_dim(input logic signed [CELL_BITS:0] v,
                                                        input logic [CFG_DIM_BITS-1:0] n);
      logic [CFG_DIM_BITS-1:0] res;
      logic signed [CELL_BITS:0] n_s;
      n_s = $signed({{(CELL_BITS + 1 - CFG_DIM_BITS){1'b0}}, n});
      if (v < 0) begin
         res = '0;
      end else if (v >= n_s) begin
         res = n - CFG_DIM_BITS'(1);
      end else begin
         res = v[CFG_DIM_BITS-1:0];
      end
      return res;
   endfunction

endpackage

// ----- design/tile_map_region_match_scan.sv -----
`timescale 1ns / 1ps

// Tile map with cell write, cell read and rectangle match scan.
// Items arrive on the req_ stream: req_tuser carries the opcode (write, read,
// scan) and req_tdata the cell, span, id range and world origin. Results leave
// on the rsp_ stream through one output register; rsp_tlast marks the final
// result of an item. Map size and tile size are set over the csr_ write port;
// the user must write them only while idle, which the block does not enforce.
// A write or read is accepted in ST_IDLE and hands its result to the output
// register from ST_ACC_OUT. A scan hands its terminator over from ST_TERM_OUT
// and visits each cell of the clamped rectangle, column by column, with one
// store read and one compare (ST_SCAN_RD, ST_SCAN_CHK); each reported hit
// then passes ST_POS_X and ST_POS_Y while one multiplier works out the x and
// then the y world position, and ST_HIT_OUT to hand it to the output register.
// The next item is accepted once the current one has handed its final result
// to the output register.
// After reset a pass clears all 4096 store entries, one entry per
// cycle; req_tready stays low during that pass. When the receiver stalls the
// result is held in the output register and the sequencer waits for it.
module tile_map_region_match_scan (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // cell_col, cell_row, span_cols, span_rows, tile_value, match_high,
   // origin_x, origin_y
   input  logic [tmrs_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // opcode
   input  logic [tmrs_pkg::REQ_USER_BITS-1:0]   req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // read_value, hit_col, hit_row, world_x, world_y, four zero pad bits
   output logic [tmrs_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // is_hit, overflow, bad_address
   output logic [tmrs_pkg::RSP_USER_BITS-1:0]   rsp_tuser,
   output logic                                  rsp_tlast,
   input  logic                                  csr_we,
   input  logic [tmrs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tmrs_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import tmrs_pkg::*;

   typedef enum logic [8:0] {
      ST_CLEAR    = 9'b000000001,
      ST_IDLE     = 9'b000000010,
      ST_ACC_OUT  = 9'b000000100,
      ST_SCAN_RD  = 9'b000001000,
      ST_SCAN_CHK = 9'b000010000,
      ST_POS_X    = 9'b000100000,
      ST_POS_Y    = 9'b001000000,
      ST_HIT_OUT  = 9'b010000000,
      ST_TERM_OUT = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [CFG_DIM_BITS-1:0]  map_columns_ff, map_rows_ff;
   logic [CFG_TILE_BITS-1:0] tile_width_ff, tile_height_ff;
   logic [CFG_DIM_BITS-1:0]  cols_used, rows_used;

   // Request fields.
   logic signed [CELL_BITS-1:0] in_col, in_row, in_span_cols, in_span_rows;
   logic [TILE_ID_BITS-1:0]     in_value, in_high;
   logic [WORLD_BITS-1:0]       in_origin_x, in_origin_y;
   logic                        accept;
   logic                        in_outside;
   logic [CFG_DIM_BITS-1:0]     sx_full, sy_full, ex_full, ey_full;
   logic [COL_BITS-1:0]         sx, ex;
   logic [ROW_BITS-1:0]         sy, ey;
   logic                        scan_empty;

   // Item context.
   logic [REQ_USER_BITS-1:0] op_ff;
   logic                     bad_ff;
   logic [ADDR_BITS-1:0]     addr_ff;
   logic [TILE_ID_BITS-1:0]  low_ff, high_ff;
   logic [WORLD_BITS-1:0]    origin_x_ff, origin_y_ff;
   logic [COL_BITS-1:0]      sx_ff, ex_ff, x_ff, x_in;
   logic [ROW_BITS-1:0]      sy_ff, ey_ff, y_ff, y_in;
   logic [HIT_CNT_BITS-1:0]  hits_ff;
   logic                     ovf_ff;
   logic [WORLD_BITS-1:0]    wx_ff;

   // Store.
   logic [TILE_ID_BITS-1:0] tile_mem [STORE_DEPTH];
   logic [TILE_ID_BITS-1:0] rd_data_ff;
   logic [ADDR_BITS-1:0]    rd_addr, wr_addr;
   logic [TILE_ID_BITS-1:0] wr_data;
   logic                    wr_en;
   logic [ADDR_BITS-1:0]    clr_ff;

   // Shared position unit.
   pos_req_type             pos_req;
   logic [WORLD_BITS-1:0]   pos_result;

   // Output register.
   logic                     rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_BITS-1:0] rsp_user_ff, rsp_user_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     out_free, out_load;

   logic                     is_match, scan_adv, scan_done;
   logic [OUT_VALUE_BITS-1:0] rd_value;

   assign cols_used = sat_dim(map_columns_ff, MAX_COLUMNS);
   assign rows_used = sat_dim(map_rows_ff, MAX_ROWS);

   assign in_col       = req_tdata[15:0];
   assign in_row       = req_tdata[31:16];
   assign in_span_cols = req_tdata[47:32];
   assign in_span_rows = req_tdata[63:48];
   assign in_value     = req_tdata[79:64];
   assign in_high      = req_tdata[95:80];
   assign in_origin_x  = req_tdata[127:96];
   assign in_origin_y  = req_tdata[159:128];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign in_outside = (in_col < 0) ||
                       (in_col >= $signed({{(CELL_BITS - CFG_DIM_BITS){1'b0}}, cols_used})) ||
                       (in_row < 0) ||
                       (in_row >= $signed({{(CELL_BITS - CFG_DIM_BITS){1'b0}}, rows_used}));

   // The rectangle start and inclusive end are each clamped into the map.
   assign sx_full = clamp_dim({in_col[CELL_BITS-1], in_col}, cols_used);
   assign sy_full = clamp_dim({in_row[CELL_BITS-1], in_row}, rows_used);
   assign ex_full = clamp_dim($signed({in_col[CELL_BITS-1], in_col}) +
                              $signed({in_span_cols[CELL_BITS-1], in_span_cols}), cols_used);
   assign ey_full = clamp_dim($signed({in_row[CELL_BITS-1], in_row}) +
                              $signed({in_span_rows[CELL_BITS-1], in_span_rows}), rows_used);
   assign sx = sx_full[COL_BITS-1:0];
   assign ex = ex_full[COL_BITS-1:0];
   assign sy = sy_full[ROW_BITS-1:0];
   assign ey = ey_full[ROW_BITS-1:0];
   assign scan_empty = (sx > ex) || (sy > ey);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         map_columns_ff <= CFG_DIM_BITS'(MAX_COLUMNS);
         map_rows_ff    <= CFG_DIM_BITS'(MAX_ROWS);
         tile_width_ff  <= CFG_TILE_BITS'(16);
         tile_height_ff <= CFG_TILE_BITS'(16);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAP_COLUMNS: begin
               map_columns_ff <= csr_wdata[CFG_DIM_BITS-1:0];
            end
            CSR_MAP_ROWS: begin
               map_rows_ff <= csr_wdata[CFG_DIM_BITS-1:0];
            end
            CSR_TILE_WIDTH_PX: begin
               tile_width_ff <= csr_wdata[CFG_TILE_BITS-1:0];
            end
            CSR_TILE_HEIGHT_PX: begin
               tile_height_ff <= csr_wdata[CFG_TILE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Store ports: the clearing pass and accepted writes share the write port.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {in_row[ROW_BITS-1:0], in_col[COL_BITS-1:0]};
      wr_data = in_value[TILE_ID_BITS-1:0];
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else if (accept && req_tuser == OP_WRITE && !in_outside) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      if (state_ff == ST_IDLE) begin
         rd_addr = {in_row[ROW_BITS-1:0], in_col[COL_BITS-1:0]};
      end else if (state_ff == ST_SCAN_RD) begin
         rd_addr = {y_ff, x_ff};
      end else begin
         rd_addr = addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tile_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= tile_mem[rd_addr];
   end

   // Position requests: x while in ST_POS_X, y otherwise, so the y position
   // stays on the unit's output while a hit waits for the output register.
   always_comb begin
      if (state_ff == ST_POS_X) begin
         pos_req.grid_pos = POS_CELL_BITS'(x_ff);
         pos_req.size     = tile_width_ff;
         pos_req.offset   = origin_x_ff;
      end else begin
         pos_req.grid_pos = POS_CELL_BITS'(y_ff);
         pos_req.size     = tile_height_ff;
         pos_req.offset   = origin_y_ff;
      end
   end

   tmrs_pos_unit u_pos (
      .clock      (clock),
      .pos_req    (pos_req),
      .pos_result (pos_result)
   );

   assign is_match  = (rd_data_ff >= low_ff) && (rd_data_ff <= high_ff);
   assign scan_done = (x_ff == ex_ff) && (y_ff == ey_ff);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Rows advance in the inner loop, columns in the outer loop.
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (y_ff == ey_ff) begin
         x_in = x_ff + COL_BITS'(1);
         y_in = sy_ff;
      end else begin
         y_in = y_ff + ROW_BITS'(1);
      end
   end

   assign rd_value = OUT_VALUE_BITS'(rd_data_ff);

   // Sequencer and result selection.
   always_comb begin
      state_in    = state_ff;
      out_load    = 1'b0;
      scan_adv    = 1'b0;
      rsp_data_in = '0;
      rsp_user_in = '0;
      rsp_last_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == ADDR_BITS'(STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == OP_SCAN) begin
                  state_in = scan_empty ? ST_TERM_OUT : ST_SCAN_RD;
               end else begin
                  state_in = ST_ACC_OUT;
               end
            end
         end
         ST_ACC_OUT: begin
            rsp_last_in = 1'b1;
            rsp_user_in[2] = bad_ff;
            if (op_ff == OP_READ && !bad_ff) begin
               rsp_data_in[15:0] = rd_value;
            end
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (is_match && hits_ff != HIT_CNT_BITS'(MAX_HITS)) begin
               state_in = ST_POS_X;
            end else begin
               scan_adv = 1'b1;
               state_in = scan_done ? ST_TERM_OUT : ST_SCAN_RD;
            end
         end
         ST_POS_X: begin
            state_in = ST_POS_Y;
         end
         ST_POS_Y: begin
            state_in = ST_HIT_OUT;
         end
         ST_HIT_OUT: begin
            rsp_user_in[0]     = 1'b1;
            rsp_data_in[21:16] = HIT_FIELD_BITS'(x_ff);
            rsp_data_in[27:22] = HIT_FIELD_BITS'(y_ff);
            rsp_data_in[59:28] = wx_ff;
            rsp_data_in[91:60] = pos_result;
            if (out_free) begin
               out_load = 1'b1;
               scan_adv = 1'b1;
               state_in = scan_done ? ST_TERM_OUT : ST_SCAN_RD;
            end
         end
         ST_TERM_OUT: begin
            rsp_last_in    = 1'b1;
            rsp_user_in[1] = ovf_ff;
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + ADDR_BITS'(1);
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item context and scan position.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_tuser;
         bad_ff      <= (req_tuser == OP_WRITE || req_tuser == OP_READ) && in_outside;
         addr_ff     <= {in_row[ROW_BITS-1:0], in_col[COL_BITS-1:0]};
         low_ff      <= in_value;
         high_ff     <= in_high;
         origin_x_ff <= in_origin_x;
         origin_y_ff <= in_origin_y;
         sx_ff       <= sx;
         ex_ff       <= ex;
         sy_ff       <= sy;
         ey_ff       <= ey;
         x_ff        <= sx;
         y_ff        <= sy;
         hits_ff     <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         if (scan_adv) begin
            x_ff <= x_in;
            y_ff <= y_in;
         end
         if (state_ff == ST_SCAN_CHK && is_match &&
             hits_ff == HIT_CNT_BITS'(MAX_HITS)) begin
            ovf_ff <= 1'b1;
         end
         if (state_ff == ST_HIT_OUT && out_load) begin
            hits_ff <= hits_ff + HIT_CNT_BITS'(1);
         end
      end
      if (state_ff == ST_POS_Y) begin
         wx_ff <= pos_result;
      end
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- design/tmrs_pos_unit.sv -----
`timescale 1ns / 1ps

module tmrs_pos_unit (
   input  logic                          clock,
   input  tmrs_pkg::pos_req_type         pos_req,
   output logic [tmrs_pkg::WORLD_BITS-1:0] pos_result
);
   import tmrs_pkg::*;

   logic [PROD_BITS-1:0]  prod_ff;
   logic [PROD_BITS-1:0]  prod_in;
   logic [WORLD_BITS-1:0] offset_ff;

   // The product is registered; the shifted add follows in the next cycle.
   assign prod_in = PROD_BITS'(pos_req.grid_pos) * PROD_BITS'(pos_req.size);

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      offset_ff <= pos_req.offset;
   end

   assign pos_result = offset_ff + WORLD_BITS'({prod_ff, {FRAC_BITS{1'b0}}});

endmodule
